// ===== sv/uvt_pkg.sv =====
// shared types, constants and compare helpers for the unique value table
package uvt_pkg;

  localparam int MAX_UNIQUE   = 256;
  localparam int MAX_ELEMENTS = 4096;
  localparam int UID_W  = $clog2(MAX_UNIQUE);
  localparam int UCNT_W = $clog2(MAX_UNIQUE + 1);
  localparam int EA_W   = $clog2(MAX_ELEMENTS);
  localparam int ECNT_W = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [1:0] {
    MODE_INSERT       = 2'd0,
    MODE_READ_UNIQUE  = 2'd1,
    MODE_READ_INVERSE = 2'd2,
    MODE_CLEAR        = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNIQUE_FULL = 2'd1,
    ST_ELEM_FULL   = 2'd2,
    ST_RANGE       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ET_INT64   = 2'd0,
    ET_INT8    = 2'd1,
    ET_FLOAT32 = 2'd2,
    ET_FLOAT64 = 2'd3
  } etype_e;

  typedef enum logic [1:0] {
    MATCH_VALUE,
    MATCH_RANK,
    MATCH_ID
  } match_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_SCAN,
    S_DONE
  } state_e;

  localparam logic [0:0] CFG_SORTED = 1'b0;
  localparam logic [0:0] CFG_ETYPE  = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] element_bits;
    logic [11:0] position;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_new;
    logic [7:0]  entry_index;
    logic [63:0] unique_bits;
    logic [11:0] first_seen_at;
    logic [12:0] occurrences;
    logic [8:0]  distinct_total;
  } res_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              load;
    logic              commit;
    match_e            match_sel;
    logic [63:0]       key;
    logic [1:0]        etype;
    logic [UID_W-1:0]  target;
    logic [UCNT_W-1:0] dcount;
    logic              hit;
    logic              add_new;
    logic [UID_W-1:0]  hit_id;
    logic [UCNT_W-1:0] less;
    logic [EA_W-1:0]   new_first;
  } bcast_t;

  // running result handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [UID_W-1:0]  id;
    logic [UCNT_W-1:0] less;
    logic [63:0]       value;
    logic [EA_W-1:0]   first;
    logic [ECNT_W-1:0] count;
    logic [UID_W-1:0]  rank;
  } acc_t;

  // keep only the bits the element type uses
  function automatic logic [63:0] mask_key(logic [63:0] v, logic [1:0] t);
    logic [63:0] m;
    m = v;
    unique case (t)
      ET_INT8:    m = {56'b0, v[7:0]};
      ET_FLOAT32: m = {32'b0, v[31:0]};
      default:    m = v;
    endcase
    return m;
  endfunction

  // signed ordering key: nan ranks above every number, +0 equals -0
  function automatic logic signed [65:0] order_key(logic [63:0] v, logic [1:0] t);
    logic signed [65:0] k;
    k = '0;
    unique case (t)
      ET_INT64: k = {{2{v[63]}}, v};
      ET_INT8:  k = {{58{v[7]}}, v[7:0]};
      ET_FLOAT32: begin
        if (v[30:0] > 31'h7F80_0000) k = {2'b01, 64'b0};
        else if (v[31]) k = -$signed({35'b0, v[30:0]});
        else k = $signed({35'b0, v[30:0]});
      end
      default: begin
        if (v[62:0] > 63'h7FF0_0000_0000_0000) k = {2'b01, 64'b0};
        else if (v[63]) k = -$signed({3'b0, v[62:0]});
        else k = $signed({3'b0, v[62:0]});
      end
    endcase
    return k;
  endfunction

endpackage

// ===== sv/uvt_ram.sv =====
// generic single write port ram with registered read
module uvt_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/uvt_cell.sv =====
// one table cell: holds a distinct value and folds itself into the passing scan
module uvt_cell import uvt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [UID_W-1:0] cell_id_i,
  input  bcast_t           bc_i,
  input  acc_t             acc_i,
  output acc_t             acc_o
);

  logic [63:0]       value_q;
  logic [EA_W-1:0]   first_q;
  logic [ECNT_W-1:0] count_q;
  logic [UID_W-1:0]  rank_q;
  logic              match_q, match_d;
  logic              lt_q, lt_d;
  acc_t              acc_q, acc_d;
  logic              active;

  assign active = {1'b0, cell_id_i} < bc_i.dcount;

  // local compare against the broadcast request
  always_comb begin
    match_d = 1'b0;
    unique case (bc_i.match_sel)
      MATCH_VALUE: match_d = order_key(value_q, bc_i.etype) == order_key(bc_i.key, bc_i.etype);
      MATCH_RANK:  match_d = rank_q == bc_i.target;
      default:     match_d = cell_id_i == bc_i.target;
    endcase
    match_d = match_d & active;
    lt_d = active & (order_key(value_q, bc_i.etype) < order_key(bc_i.key, bc_i.etype));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      lt_q    <= 1'b0;
    end else if (bc_i.load) begin
      match_q <= match_d;
      lt_q    <= lt_d;
    end
  end

  // fold this cell into the scan
  always_comb begin
    acc_d = acc_i;
    acc_d.less = acc_i.less + UCNT_W'(lt_q);
    if (match_q) begin
      acc_d.found = 1'b1;
      acc_d.id    = cell_id_i;
      acc_d.value = value_q;
      acc_d.first = first_q;
      acc_d.count = count_q;
      acc_d.rank  = rank_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

  // commit of an insert
  always_ff @(posedge clk_i) begin
    if (bc_i.commit) begin
      if (bc_i.hit && bc_i.hit_id == cell_id_i) count_q <= count_q + 1'b1;
      if (bc_i.add_new) begin
        if (active && {1'b0, rank_q} >= bc_i.less) rank_q <= rank_q + 1'b1;
        if ({1'b0, cell_id_i} == bc_i.dcount) begin
          value_q <= bc_i.key;
          first_q <= bc_i.new_first;
          count_q <= ECNT_W'(1);
          rank_q  <= bc_i.less[UID_W-1:0];
        end
      end
    end
  end

endmodule

// ===== sv/uvt_ctrl.sv =====
// sequencer: request decode, scan timing, commit and result register
module uvt_ctrl import uvt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  req_t             req_i,
  output logic             busy_o,
  output logic             done_o,
  output res_t             res_o,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [1:0]       cfg_data_i,
  output bcast_t           bc_o,
  input  acc_t             acc_i,
  output logic             ram_we_o,
  output logic [EA_W-1:0]  ram_waddr_o,
  output logic [UID_W-1:0] ram_wdata_o,
  output logic [EA_W-1:0]  ram_raddr_o,
  input  logic [UID_W-1:0] ram_rdata_i
);

  state_e            state_q, state_d;
  logic              sorted_q;
  logic [1:0]        etype_q;
  logic [UCNT_W-1:0] dc_q, dc_d;
  logic [ECNT_W-1:0] ec_q, ec_d;
  logic [1:0]        mode_q;
  logic [63:0]       key_q;
  logic [UID_W-1:0]  target_q;
  logic [UCNT_W-1:0] cnt_q;
  res_t              res_q, res_d;
  logic              done_q, done_d;
  logic              accept;
  logic              pos_in_dc, pos_in_ec, ec_full, dc_full;

  assign accept    = start_i & (state_q == S_IDLE);
  assign pos_in_dc = {1'b0, req_i.position} < 13'(dc_q);
  assign pos_in_ec = ECNT_W'(req_i.position) < ec_q;
  assign ec_full   = ec_q >= ECNT_W'(MAX_ELEMENTS);
  assign dc_full   = dc_q >= UCNT_W'(MAX_UNIQUE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.mode)
            MODE_INSERT:       if (!ec_full) state_d = S_LOAD;
            MODE_READ_UNIQUE:  if (pos_in_dc) state_d = S_LOAD;
            MODE_READ_INVERSE: if (pos_in_ec) state_d = S_FETCH;
            default:           state_d = S_IDLE;
          endcase
        end
      end
      S_FETCH: state_d = S_LOAD;
      S_LOAD:  state_d = S_SCAN;
      S_SCAN:  if (cnt_q == UCNT_W'(MAX_UNIQUE - 1)) state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs: broadcast, element store write, result
  always_comb begin
    bc_o = '0;
    bc_o.load      = state_q == S_LOAD;
    bc_o.key       = key_q;
    bc_o.etype     = etype_q;
    bc_o.target    = target_q;
    bc_o.dcount    = dc_q;
    bc_o.hit_id    = acc_i.id;
    bc_o.less      = acc_i.less;
    bc_o.new_first = ec_q[EA_W-1:0];
    if (mode_q == MODE_INSERT) bc_o.match_sel = MATCH_VALUE;
    else if (mode_q == MODE_READ_UNIQUE && sorted_q) bc_o.match_sel = MATCH_RANK;
    else bc_o.match_sel = MATCH_ID;

    ram_we_o    = 1'b0;
    ram_waddr_o = ec_q[EA_W-1:0];
    ram_wdata_o = acc_i.id;
    ram_raddr_o = EA_W'(req_i.position);

    res_d  = '0;
    done_d = 1'b0;
    dc_d   = dc_q;
    ec_d   = ec_q;

    // requests answered at once
    if (accept) begin
      res_d.distinct_total = 9'(dc_q);
      unique case (req_i.mode)
        MODE_INSERT: if (ec_full) begin
          res_d.status = ST_ELEM_FULL;
          done_d = 1'b1;
        end
        MODE_READ_UNIQUE: if (!pos_in_dc) begin
          res_d.status = ST_RANGE;
          done_d = 1'b1;
        end
        MODE_READ_INVERSE: if (!pos_in_ec) begin
          res_d.status = ST_RANGE;
          done_d = 1'b1;
        end
        default: begin
          dc_d = '0;
          ec_d = '0;
          res_d.distinct_total = '0;
          done_d = 1'b1;
        end
      endcase
    end

    // end of scan
    if (state_q == S_DONE) begin
      done_d = 1'b1;
      res_d.distinct_total = 9'(dc_q);
      if (mode_q == MODE_INSERT) begin
        if (acc_i.found) begin
          bc_o.commit = 1'b1;
          bc_o.hit    = 1'b1;
          ram_we_o    = 1'b1;
          ec_d        = ec_q + 1'b1;
          res_d.entry_index   = 8'(acc_i.id);
          res_d.unique_bits   = acc_i.value;
          res_d.first_seen_at = 12'(acc_i.first);
          res_d.occurrences   = 13'(acc_i.count + 1'b1);
        end else if (dc_full) begin
          res_d.status = ST_UNIQUE_FULL;
        end else begin
          bc_o.commit  = 1'b1;
          bc_o.add_new = 1'b1;
          ram_we_o     = 1'b1;
          ram_wdata_o  = dc_q[UID_W-1:0];
          ec_d         = ec_q + 1'b1;
          dc_d         = dc_q + 1'b1;
          res_d.is_new         = 1'b1;
          res_d.entry_index    = 8'(dc_q);
          res_d.unique_bits    = key_q;
          res_d.first_seen_at  = 12'(ec_q);
          res_d.occurrences    = 13'd1;
          res_d.distinct_total = 9'(dc_q + 1'b1);
        end
      end else begin
        res_d.entry_index   = (mode_q == MODE_READ_INVERSE && sorted_q) ?
                              8'(acc_i.rank) : 8'(acc_i.id);
        res_d.unique_bits   = acc_i.value;
        res_d.first_seen_at = 12'(acc_i.first);
        res_d.occurrences   = 13'(acc_i.count);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sorted_q <= 1'b1;
      etype_q  <= ET_INT64;
      dc_q     <= '0;
      ec_q     <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      dc_q    <= dc_d;
      ec_q    <= ec_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SORTED: sorted_q <= cfg_data_i[0];
          default:    etype_q  <= cfg_data_i;
        endcase
      end
      if (state_q == S_LOAD) cnt_q <= '0;
      else if (state_q == S_SCAN) cnt_q <= cnt_q + 1'b1;
    end
  end

  // request payload and result
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      mode_q   <= req_i.mode;
      key_q    <= mask_key(req_i.element_bits, etype_q);
      target_q <= UID_W'(req_i.position);
    end
    if (state_q == S_FETCH) target_q <= ram_rdata_i;
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== sv/unique_value_table.sv =====
// top level of the unique value table: controller, cell chain, element store
//
//  channel   ports                           handshake
//  request   start_i, req_i                  taken when start_i high and busy_o low
//  result    done_o, res_o                   one-cycle strobe, receiver cannot stall
//  config    cfg_we_i, cfg_idx_i, cfg_data_i write on cfg_we_i, no wait
//
// clear, element-store-full and out-of-range requests answer in the cycle after acceptance.
// insert and unique reads pass the load, scan and done states; inverse reads first
// pass a fetch state for the element store read; the scan runs down the cell chain.
// busy_o stays high until the result strobe; one request is worked at a time.
// reset empties the table; no clearing pass is needed.
module unique_value_table import uvt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  req_t       req_i,
  output logic       busy_o,
  output logic       done_o,
  output res_t       res_o,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [1:0] cfg_data_i
);

  bcast_t           bc;
  acc_t             chain [MAX_UNIQUE+1];
  logic             ram_we;
  logic [EA_W-1:0]  ram_waddr, ram_raddr;
  logic [UID_W-1:0] ram_wdata, ram_rdata;

  // sequencer
  uvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .bc_o        (bc),
    .acc_i       (chain[MAX_UNIQUE]),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // chain of cells, scan enters at cell zero
  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_UNIQUE; i++) begin : g_cell
    uvt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (UID_W'(i)),
      .bc_i      (bc),
      .acc_i     (chain[i]),
      .acc_o     (chain[i+1])
    );
  end

  // per-element appearance id store
  uvt_ram #(
    .Width (UID_W),
    .Depth (MAX_ELEMENTS)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
